[rtl/cda_pkg.sv]
// Shared types, constants and calendar tables for the calendar date adder.
// Depends on nothing; imported by cda_ctrl, cda_dp and calendar_date_adder.
package cda_pkg;

	localparam int YearW  = 14;
	localparam int MonthW = 4;
	localparam int DayW   = 5;
	localparam int AmtW   = 15;
	localparam int OpW    = 2;

	// working year is wide enough for 9999 + 32767
	localparam int WyW    = 16;
	localparam int CentW  = 9;
	localparam int RcW    = 7;
	localparam int ProdW  = 32;
	localparam int DoyW   = 9;

	localparam logic [WyW-1:0]    MaxYear     = WyW'(9999);
	localparam logic [MonthW-1:0] LastMonth   = MonthW'(12);
	localparam logic [DayW-1:0]   LastDay     = DayW'(31);
	// (y * RecipHundred) >> RecipShift equals y / 100 for y below 43699
	localparam logic [ProdW-1:0]  RecipHundred = ProdW'(5243);
	// (t * RecipTwelve) >> RecipShift equals t / 12 for t below 2^17
	localparam logic [ProdW-1:0]  RecipTwelve  = ProdW'(43691);
	localparam int                RecipShift   = 19;

	typedef enum logic [OpW-1:0] {
		OP_DAYS   = 2'd0,
		OP_MONTHS = 2'd1,
		OP_YEARS  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic div_mul;
		logic div_cent;
		logic div_rem;
		logic clamp;
		logic day_step;
		logic mdiv_mul;
		logic mdiv_apply;
		logic add_years;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		opcode_t op;
		logic    rem_zero;
		logic    yr_over;
		logic    out_free;
	} sts_t;

	// days in a month, February by the leap flag
	function automatic logic [DayW-1:0] month_len(input logic leap, input logic [MonthW-1:0] mo);
		logic [DayW-1:0] len;
		case (mo) inside
			4'd2:                    len = leap ? DayW'(29) : DayW'(28);
			4'd4, 4'd6, 4'd9, 4'd11: len = DayW'(30);
			default:                 len = DayW'(31);
		endcase
		return len;
	endfunction

	// days before the first of a month in a common year
	function automatic logic [DoyW-1:0] cum_days(input logic [MonthW-1:0] mo);
		logic [DoyW-1:0] n;
		case (mo)
			4'd2:    n = DoyW'(31);
			4'd3:    n = DoyW'(59);
			4'd4:    n = DoyW'(90);
			4'd5:    n = DoyW'(120);
			4'd6:    n = DoyW'(151);
			4'd7:    n = DoyW'(181);
			4'd8:    n = DoyW'(212);
			4'd9:    n = DoyW'(243);
			4'd10:   n = DoyW'(273);
			4'd11:   n = DoyW'(304);
			4'd12:   n = DoyW'(334);
			default: n = DoyW'(0);
		endcase
		return n;
	endfunction

endpackage

[rtl/cda_ctrl.sv]
// Sequencer for the calendar date adder: steps the datapath through year
// decomposition, day clamping and the per-opcode work. Depends on cda_pkg.
module cda_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cda_pkg::sts_t sts,
	output cda_pkg::cmd_t cmd
);
	import cda_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DMUL,
		S_DCEN,
		S_DREM,
		S_CLAMP,
		S_DAYS,
		S_MMUL,
		S_MAPP,
		S_YADD,
		S_FIN
	} state_t;

	state_t state_q;
	logic   pass2_q;

	assign in_ready = (state_q == S_IDLE);

	// decode commands from the current state
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:  cmd.load_in    = in_valid;
			S_DMUL:  cmd.div_mul    = 1'b1;
			S_DCEN:  cmd.div_cent   = 1'b1;
			S_DREM:  cmd.div_rem    = 1'b1;
			S_CLAMP: cmd.clamp      = 1'b1;
			S_DAYS:  cmd.day_step   = !(sts.rem_zero || sts.yr_over);
			S_MMUL:  cmd.mdiv_mul   = 1'b1;
			S_MAPP:  cmd.mdiv_apply = 1'b1;
			S_YADD:  cmd.add_years  = 1'b1;
			S_FIN:   cmd.load_out   = sts.out_free;
			default: cmd = '0;
		endcase
	end

	// advance the sequence; the second pass ends after its clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass2_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DMUL;
						pass2_q <= 1'b0;
					end
				end
				S_DMUL:  state_q <= S_DCEN;
				S_DCEN:  state_q <= S_DREM;
				S_DREM:  state_q <= S_CLAMP;
				S_CLAMP: begin
					if (pass2_q) begin
						state_q <= S_FIN;
					end else begin
						unique case (sts.op)
							OP_DAYS:   state_q <= S_DAYS;
							OP_MONTHS: state_q <= S_MMUL;
							OP_YEARS:  state_q <= S_YADD;
							default:   state_q <= S_FIN;
						endcase
					end
				end
				S_DAYS: begin
					if (sts.rem_zero || sts.yr_over) state_q <= S_FIN;
				end
				S_MMUL:  state_q <= S_MAPP;
				S_MAPP: begin
					state_q <= S_DMUL;
					pass2_q <= 1'b1;
				end
				S_YADD: begin
					state_q <= S_DMUL;
					pass2_q <= 1'b1;
				end
				S_FIN: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/cda_dp.sv]
// Datapath for the calendar date adder: working date, remaining amount,
// year split into centuries and remainder, and the output register. Depends on cda_pkg.
module cda_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cda_pkg::cmd_t               cmd,
	output cda_pkg::sts_t               sts,
	input  logic [cda_pkg::OpW-1:0]     opcode,
	input  logic [cda_pkg::YearW-1:0]   year,
	input  logic [cda_pkg::MonthW-1:0]  month,
	input  logic [cda_pkg::DayW-1:0]    day,
	input  logic [cda_pkg::AmtW-1:0]    amount,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [cda_pkg::YearW-1:0]   new_year,
	output logic [cda_pkg::MonthW-1:0]  new_month,
	output logic [cda_pkg::DayW-1:0]    new_day,
	output logic                        year_overflow
);
	import cda_pkg::*;

	opcode_t            op_q;
	logic [WyW-1:0]     yr_q;
	logic [MonthW-1:0]  mo_q;
	logic [DayW-1:0]    dy_q;
	logic [AmtW-1:0]    rem_q;
	logic [CentW-1:0]   cent_q;
	logic [RcW-1:0]     rc_q;
	logic [ProdW-1:0]   prod_q;

	logic [YearW-1:0]   oyear_q;
	logic [MonthW-1:0]  omonth_q;
	logic [DayW-1:0]    oday_q;
	logic               oovf_q;
	logic               ovalid_q;

	logic               leap;
	logic               yr_over;
	logic [DayW-1:0]    mlen;
	logic [DoyW-1:0]    doy;
	logic [DoyW-1:0]    ylen;
	logic [WyW-1:0]     cent_x100;
	logic [WyW-1:0]     mtot;
	logic [11:0]        q12;
	logic [WyW-1:0]     q12_x12;
	logic               cross_year;
	logic               cross_month;

	// leap rule from the century split: divisible by 4, and not a whole
	// century unless the century count is divisible by 4
	assign leap    = (yr_q[1:0] == 2'b00) && ((rc_q != '0) || (cent_q[1:0] == 2'b00));
	assign yr_over = (yr_q > MaxYear);
	assign mlen    = month_len(leap, mo_q);
	assign doy     = cum_days(mo_q) + DoyW'(dy_q)
	               + DoyW'(leap && (mo_q > MonthW'(2)));
	assign ylen    = leap ? DoyW'(366) : DoyW'(365);

	assign cent_x100 = WyW'(cent_q) * WyW'(100);
	assign mtot      = WyW'(mo_q) - WyW'(1) + WyW'(rem_q);
	assign q12       = prod_q[RecipShift+11:RecipShift];
	assign q12_x12   = WyW'(q12) * WyW'(12);

	assign cross_year  = (WyW'(rem_q) + WyW'(doy)) > WyW'(ylen);
	assign cross_month = (WyW'(rem_q) + WyW'(dy_q)) > WyW'(mlen);

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= opcode_t'(opcode);
			yr_q  <= (WyW'(year) > MaxYear) ? MaxYear : WyW'(year);
			if (month == '0)
				mo_q <= MonthW'(1);
			else if (month > LastMonth)
				mo_q <= LastMonth;
			else
				mo_q <= month;
			dy_q  <= (day == '0) ? DayW'(1) : day;
			rem_q <= amount;
		end
		if (cmd.div_mul) begin
			prod_q <= ProdW'(yr_q) * RecipHundred;
		end
		if (cmd.div_cent) begin
			cent_q <= prod_q[RecipShift+CentW-1:RecipShift];
		end
		if (cmd.div_rem) begin
			rc_q <= RcW'(yr_q - cent_x100);
		end
		if (cmd.clamp) begin
			if (dy_q > mlen) dy_q <= mlen;
		end
		if (cmd.mdiv_mul) begin
			prod_q <= ProdW'(mtot) * RecipTwelve;
		end
		if (cmd.mdiv_apply) begin
			yr_q <= yr_q + WyW'(q12);
			mo_q <= MonthW'(mtot - q12_x12 + WyW'(1));
		end
		if (cmd.add_years) begin
			yr_q <= yr_q + WyW'(rem_q);
		end
		// one year, one month or the final days per step
		if (cmd.day_step) begin
			if (cross_year) begin
				rem_q <= rem_q - AmtW'(ylen - doy + DoyW'(1));
				yr_q  <= yr_q + WyW'(1);
				mo_q  <= MonthW'(1);
				dy_q  <= DayW'(1);
				if (rc_q == RcW'(99)) begin
					rc_q   <= '0;
					cent_q <= cent_q + CentW'(1);
				end else begin
					rc_q <= rc_q + RcW'(1);
				end
			end else if (cross_month) begin
				rem_q <= rem_q - AmtW'(mlen - dy_q + DayW'(1));
				mo_q  <= mo_q + MonthW'(1);
				dy_q  <= DayW'(1);
			end else begin
				dy_q  <= dy_q + DayW'(rem_q);
				rem_q <= '0;
			end
		end
	end

	// output payload, saturated on year overflow
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			oovf_q   <= yr_over;
			oyear_q  <= yr_over ? YearW'(MaxYear) : YearW'(yr_q);
			omonth_q <= yr_over ? LastMonth : mo_q;
			oday_q   <= yr_over ? LastDay : dy_q;
		end
	end

	// output valid: set on load, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	assign sts.op       = op_q;
	assign sts.rem_zero = (rem_q == '0);
	assign sts.yr_over  = yr_over;
	assign sts.out_free = !ovalid_q || out_ready;

	assign out_valid     = ovalid_q;
	assign new_year      = oyear_q;
	assign new_month     = omonth_q;
	assign new_day       = oday_q;
	assign year_overflow = oovf_q;

endmodule

[rtl/calendar_date_adder.sv]
// Opcode 3 ends after year decomposition and day clamp; years and months add and then
// repeat both; days step once per whole year, whole month and final partial month
// crossed. Throughput: one item at a time; the day loop steps once per cycle, and
// the next item is taken once the result is in the output register.
// Reset (arst_n, asynchronous): sequencer idle, no result pending.
// Depends on cda_pkg, cda_ctrl and cda_dp.
module calendar_date_adder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [cda_pkg::OpW-1:0]     opcode,
	input  logic [cda_pkg::YearW-1:0]   year,
	input  logic [cda_pkg::MonthW-1:0]  month,
	input  logic [cda_pkg::DayW-1:0]    day,
	input  logic [cda_pkg::AmtW-1:0]    amount,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [cda_pkg::YearW-1:0]   new_year,
	output logic [cda_pkg::MonthW-1:0]  new_month,
	output logic [cda_pkg::DayW-1:0]    new_day,
	output logic                        year_overflow
);
	import cda_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	cda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// date arithmetic and output register
	cda_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (opcode),
		.year          (year),
		.month         (month),
		.day           (day),
		.amount        (amount),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.new_year      (new_year),
		.new_month     (new_month),
		.new_day       (new_day),
		.year_overflow (year_overflow)
	);

endmodule
